>>> rtl/ffsa_pkg.sv
// ----------------------------------------------------------------------------
// ffsa_pkg
// types, codes and defaults for the first-fit segment allocator
// ----------------------------------------------------------------------------
`default_nettype none
package ffsa_pkg;

  localparam int FREE_ENTRIES_DEF = 16;
  localparam int USED_ENTRIES_DEF = 16;
  localparam int SEGMENT_SIZE_DEF = 65535;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_ZERO = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  typedef struct packed {
    logic        func;
    logic        segment;
    logic [15:0] length;
    logic [15:0] block_address;
    logic [7:0]  owner_id;
  } req_t;

  typedef struct packed {
    logic [15:0] result_address;
    logic [1:0]  status;
  } rsp_t;

  typedef struct packed {
    logic [15:0] base;
    logic [15:0] size;
  } free_ent_t;

  typedef struct packed {
    logic [15:0] base;
    logic [15:0] size;
    logic [7:0]  owner;
  } used_ent_t;

  typedef enum logic [3:0] {
    S_IDLE, S_ARD, S_ACMP, S_ASRD, S_ASWR, S_FRD, S_FCMP,
    S_URD, S_UWR, S_IRD, S_IWR, S_DONE
  } state_t;

endpackage
`default_nettype wire

>>> rtl/first_fit_segment_allocator_top.sv
// ----------------------------------------------------------------------------
// first_fit_segment_allocator_top
// first-fit allocator with free and used lists for two segments
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; busy then stays high
// until the single response has been shown on response for one cycle with
// done high, which the receiver must take as it comes. All list work runs
// through one sequencer over two RAMs (free list, used list), each with a read
// port and a write port: allocate scans the free entries in order and, on an
// exact fit, moves each later free entry down; free scans the used entries for
// the block, moves each later used entry down, then moves each free entry up
// for the head insert. A zero-length allocate goes straight to the response.
// No clearing pass after reset.
`default_nettype none
module first_fit_segment_allocator_top
  import ffsa_pkg::*;
#(
  parameter int FREE_ENTRIES = FREE_ENTRIES_DEF,
  parameter int USED_ENTRIES = USED_ENTRIES_DEF,
  parameter int SEGMENT_SIZE = SEGMENT_SIZE_DEF
) (
  input  wire  clk,
  input  wire  rst,
  input  wire  start,
  input  req_t request,
  output logic busy,
  output logic done,
  output rsp_t response
);

  localparam int FW   = $clog2(FREE_ENTRIES);
  localparam int UW   = $clog2(USED_ENTRIES);
  localparam int FCW  = $clog2(FREE_ENTRIES + 1);
  localparam int UCW  = $clog2(USED_ENTRIES + 1);
  localparam int MAXE = (FREE_ENTRIES > USED_ENTRIES) ? FREE_ENTRIES : USED_ENTRIES;
  localparam int IW   = $clog2(MAXE + 1);
  localparam logic [15:0] INIT_SIZE = 16'(SEGMENT_SIZE);

  state_t state, state_next;
  req_t   req;
  rsp_t   rsp, rsp_next;
  logic [IW-1:0] idx, idx_next, idx_inc, idx_dec;
  logic [15:0] sz, sz_next;
  logic [FCW-1:0] free_count [2];
  logic [FCW-1:0] free_count_next [2];
  logic [UCW-1:0] used_count [2];
  logic [UCW-1:0] used_count_next [2];
  logic [1:0] init0;

  free_ent_t free_mem [2**(FW+1)];
  used_ent_t used_mem [2**(UW+1)];
  free_ent_t fr_data, fd, fw_data;
  used_ent_t ur_data, uw_data;
  logic fr_en, fw_en, ur_en, uw_en, fr_init;
  logic [FW:0] fr_addr, fw_addr;
  logic [UW:0] ur_addr, uw_addr;
  logic [IW-1:0] fn, un;

  always_ff @(posedge clk) begin
    if (fw_en) free_mem[fw_addr] <= fw_data;
    if (fr_en) fr_data <= free_mem[fr_addr];
    if (uw_en) used_mem[uw_addr] <= uw_data;
    if (ur_en) ur_data <= used_mem[ur_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      init0   <= '0;
      fr_init <= 1'b0;
    end else begin
      fr_init <= fr_en && (fr_addr[FW-1:0] == '0) && !init0[fr_addr[FW]];
      if (fw_en && fw_addr[FW-1:0] == '0) init0[fw_addr[FW]] <= 1'b1;
    end
  end

  assign fd = fr_init ? '{base: 16'd0, size: INIT_SIZE} : fr_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      free_count[0] <= FCW'(1);
      free_count[1] <= FCW'(1);
      used_count[0] <= '0;
      used_count[1] <= '0;
    end else begin
      state         <= state_next;
      free_count[0] <= free_count_next[0];
      free_count[1] <= free_count_next[1];
      used_count[0] <= used_count_next[0];
      used_count[1] <= used_count_next[1];
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) req <= request;
    idx <= idx_next;
    sz  <= sz_next;
    rsp <= rsp_next;
  end

  assign busy     = (state != S_IDLE);
  assign done     = (state == S_DONE);
  assign response = rsp;
  assign fn       = IW'(free_count[req.segment]);
  assign un       = IW'(used_count[req.segment]);
  assign idx_inc  = idx + IW'(1);
  assign idx_dec  = idx - IW'(1);

  always_comb begin
    state_next         = state;
    idx_next           = idx;
    sz_next            = sz;
    rsp_next           = rsp;
    free_count_next[0] = free_count[0];
    free_count_next[1] = free_count[1];
    used_count_next[0] = used_count[0];
    used_count_next[1] = used_count[1];
    fr_en   = 1'b0;
    fr_addr = {req.segment, idx[FW-1:0]};
    fw_en   = 1'b0;
    fw_addr = {req.segment, idx[FW-1:0]};
    fw_data = fd;
    ur_en   = 1'b0;
    ur_addr = {req.segment, idx[UW-1:0]};
    uw_en   = 1'b0;
    uw_addr = {req.segment, idx[UW-1:0]};
    uw_data = ur_data;
    unique case (state)
      S_IDLE: begin
        idx_next = '0;
        rsp_next = '{result_address: 16'd0, status: ST_OK};
        if (start) begin
          if (request.func == FUNC_FREE) begin
            state_next = S_FRD;
          end else if (request.length == 16'd0) begin
            rsp_next.status = ST_ZERO;
            state_next = S_DONE;
          end else begin
            state_next = S_ARD;
          end
        end
      end
      S_ARD: begin
        if (idx >= fn) begin
          rsp_next.status = ST_MISS;
          state_next = S_DONE;
        end else begin
          fr_en = 1'b1;
          state_next = S_ACMP;
        end
      end
      S_ACMP: begin
        if (fd.size >= req.length) begin
          if (used_count[req.segment] >= UCW'(USED_ENTRIES)) begin
            rsp_next.status = ST_FULL;
            state_next = S_DONE;
          end else begin
            uw_en   = 1'b1;
            uw_addr = {req.segment, used_count[req.segment][UW-1:0]};
            uw_data = '{base: fd.base, size: req.length, owner: req.owner_id};
            used_count_next[req.segment] = used_count[req.segment] + UCW'(1);
            rsp_next.result_address = fd.base;
            if (fd.size == req.length) begin
              state_next = S_ASRD;
            end else begin
              fw_en   = 1'b1;
              fw_data = '{base: fd.base + req.length, size: fd.size - req.length};
              state_next = S_DONE;
            end
          end
        end else begin
          idx_next = idx_inc;
          state_next = S_ARD;
        end
      end
      S_ASRD: begin
        if (idx_inc >= fn) begin
          free_count_next[req.segment] = free_count[req.segment] - FCW'(1);
          state_next = S_DONE;
        end else begin
          fr_en   = 1'b1;
          fr_addr = {req.segment, idx_inc[FW-1:0]};
          state_next = S_ASWR;
        end
      end
      S_ASWR: begin
        fw_en    = 1'b1;
        idx_next = idx_inc;
        state_next = S_ASRD;
      end
      S_FRD: begin
        if (idx >= un) begin
          rsp_next.status = ST_MISS;
          state_next = S_DONE;
        end else begin
          ur_en = 1'b1;
          state_next = S_FCMP;
        end
      end
      S_FCMP: begin
        if (ur_data.base == req.block_address) begin
          if (free_count[req.segment] >= FCW'(FREE_ENTRIES)) begin
            rsp_next.status = ST_FULL;
            state_next = S_DONE;
          end else begin
            sz_next = ur_data.size;
            state_next = S_URD;
          end
        end else begin
          idx_next = idx_inc;
          state_next = S_FRD;
        end
      end
      S_URD: begin
        if (idx_inc >= un) begin
          used_count_next[req.segment] = used_count[req.segment] - UCW'(1);
          idx_next = fn;
          state_next = S_IRD;
        end else begin
          ur_en   = 1'b1;
          ur_addr = {req.segment, idx_inc[UW-1:0]};
          state_next = S_UWR;
        end
      end
      S_UWR: begin
        uw_en    = 1'b1;
        idx_next = idx_inc;
        state_next = S_URD;
      end
      S_IRD: begin
        if (idx == '0) begin
          fw_en   = 1'b1;
          fw_data = '{base: req.block_address, size: sz};
          free_count_next[req.segment] = free_count[req.segment] + FCW'(1);
          state_next = S_DONE;
        end else begin
          fr_en   = 1'b1;
          fr_addr = {req.segment, idx_dec[FW-1:0]};
          state_next = S_IWR;
        end
      end
      S_IWR: begin
        fw_en    = 1'b1;
        idx_next = idx_dec;
        state_next = S_IRD;
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(busy) || $past(start))) else $error("response without a transaction");
  a_err_zero_addr: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.status != ST_OK) |-> (rsp.result_address == 16'd0))
    else $error("error response with nonzero address");
  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    (free_count[0] <= FCW'(FREE_ENTRIES)) && (free_count[1] <= FCW'(FREE_ENTRIES)))
    else $error("free count overflow");
  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    (used_count[0] <= UCW'(USED_ENTRIES)) && (used_count[1] <= UCW'(USED_ENTRIES)))
    else $error("used count overflow");

endmodule
`default_nettype wire

>>> tb/first_fit_segment_allocator_top_test.sv
// ----------------------------------------------------------------------------
// first_fit_segment_allocator_top_test
// Checks the two-segment first-fit allocator against its own list model.
// A queue-fed driver issues allocate and free transactions with random gaps.
// A monitor compares each response with the oldest predicted response. The
// stimulus covers exact fits, full tables, an empty free list and misses.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module first_fit_segment_allocator_top_test;
  import ffsa_pkg::*;

  localparam int NFREE = FREE_ENTRIES_DEF;
  localparam int NUSED = USED_ENTRIES_DEF;
  localparam int CYCLE_LIMIT = 1500000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  req_t request = '0;
  logic busy, done;
  rsp_t response;

  first_fit_segment_allocator_top u_dut (
    .clk(clk), .rst(rst), .start(start), .request(request),
    .busy(busy), .done(done), .response(response)
  );

  always #2 clk = ~clk;

  // model state
  logic [15:0] fl_base [2][NFREE];
  logic [15:0] fl_size [2][NFREE];
  int          fl_cnt  [2];
  logic [15:0] ul_base [2][NUSED];
  logic [15:0] ul_size [2][NUSED];
  logic [7:0]  ul_owner[2][NUSED];
  int          ul_cnt  [2];

  req_t pending_reqs[$];
  rsp_t expected_rsps[$];
  int   errors = 0;
  int   cycles = 0;
  int   n_sent = 0;
  int   n_checked = 0;
  int   status_seen[4] = '{0, 0, 0, 0};
  int   gap_left = 0;
  bit   quiet = 1'b0;
  bit   drain_hold = 1'b0;

  function automatic rsp_t predict_alloc_free(req_t r);
    rsp_t o;
    int s, i, k, n;
    logic [15:0] b, sz;
    o = '0;
    s = r.segment;
    if (r.func == FUNC_ALLOC) begin
      n = fl_cnt[s];
      if (r.length == 0) begin
        o.status = ST_ZERO;
        return o;
      end
      for (i = 0; i < n; i++) if (fl_size[s][i] >= r.length) break;
      if (i >= n) begin
        o.status = ST_MISS;
        return o;
      end
      if (ul_cnt[s] >= NUSED) begin
        o.status = ST_FULL;
        return o;
      end
      b = fl_base[s][i];
      ul_base[s][ul_cnt[s]] = b;
      ul_size[s][ul_cnt[s]] = r.length;
      ul_owner[s][ul_cnt[s]] = r.owner_id;
      ul_cnt[s]++;
      if (fl_size[s][i] == r.length) begin
        for (k = i; k + 1 < n; k++) begin
          fl_base[s][k] = fl_base[s][k+1];
          fl_size[s][k] = fl_size[s][k+1];
        end
        fl_cnt[s] = n - 1;
      end else begin
        fl_base[s][i] = b + r.length;
        fl_size[s][i] = fl_size[s][i] - r.length;
      end
      o.result_address = b;
      o.status = ST_OK;
    end else begin
      n = ul_cnt[s];
      for (i = 0; i < n; i++) if (ul_base[s][i] == r.block_address) break;
      if (i >= n) begin
        o.status = ST_MISS;
        return o;
      end
      if (fl_cnt[s] >= NFREE) begin
        o.status = ST_FULL;
        return o;
      end
      sz = ul_size[s][i];
      for (k = i; k + 1 < n; k++) begin
        ul_base[s][k] = ul_base[s][k+1];
        ul_size[s][k] = ul_size[s][k+1];
        ul_owner[s][k] = ul_owner[s][k+1];
      end
      ul_cnt[s] = n - 1;
      for (k = fl_cnt[s]; k > 0; k--) begin
        fl_base[s][k] = fl_base[s][k-1];
        fl_size[s][k] = fl_size[s][k-1];
      end
      fl_base[s][0] = r.block_address;
      fl_size[s][0] = sz;
      fl_cnt[s]++;
      o.status = ST_OK;
    end
    return o;
  endfunction

  // shadow of live bases per segment, for building valid frees
  logic [15:0] live_bases[2][$];
  logic [15:0] live_lens[2][$];

  function automatic req_t make_req(logic f, logic sg, logic [15:0] len,
                                    logic [15:0] adr, logic [7:0] own);
    req_t r;
    r.func = f;
    r.segment = sg;
    r.length = len;
    r.block_address = adr;
    r.owner_id = own;
    return r;
  endfunction

  // generator side: queue a request for the driver
  task automatic push_req(req_t r);
    pending_reqs.push_back(r);
  endtask

  function automatic req_t random_req(int sel);
    req_t r;
    logic sg;
    int q;
    sg = $urandom_range(0, 1);
    r = make_req(FUNC_ALLOC, sg, 16'($urandom), 16'($urandom), 8'($urandom));
    case (sel)
      0: begin
        r.length = 16'($urandom_range(1, 64));
      end
      1: begin
        r.length = 16'($urandom_range(1, 4096));
      end
      2: begin
        r.func = FUNC_FREE;
        if (live_bases[sg].size() > 0) begin
          q = $urandom_range(0, live_bases[sg].size() - 1);
          r.block_address = live_bases[sg][q];
        end
      end
      3: begin
        r.func = FUNC_FREE;
        if (live_bases[sg].size() > 0)
          r.block_address = live_bases[sg][$urandom_range(0,
                                           live_bases[sg].size() - 1)];
      end
      4: begin
        r.func = FUNC_FREE;
      end
      5: begin
        if (live_lens[sg].size() > 0)
          r.length = live_lens[sg][$urandom_range(0, live_lens[sg].size() - 1)];
      end
      default: begin
        if ($urandom_range(0, 3) == 0) r.length = 16'd0;
      end
    endcase
    return r;
  endfunction

  // keep the generator's view of live blocks in step with a shadow model
  logic [15:0] g_fb[2][NFREE];
  logic [15:0] g_fs[2][NFREE];
  int g_fc[2];
  logic [15:0] g_ub[2][NUSED];
  logic [15:0] g_us[2][NUSED];
  int g_uc[2];

  task automatic shadow_apply(req_t r);
    int s, i, k;
    logic [15:0] b, sz;
    s = r.segment;
    if (r.func == FUNC_ALLOC) begin
      if (r.length == 0) return;
      for (i = 0; i < g_fc[s]; i++) if (g_fs[s][i] >= r.length) break;
      if (i >= g_fc[s] || g_uc[s] >= NUSED) return;
      b = g_fb[s][i];
      g_ub[s][g_uc[s]] = b;
      g_us[s][g_uc[s]] = r.length;
      g_uc[s]++;
      if (g_fs[s][i] == r.length) begin
        for (k = i; k + 1 < g_fc[s]; k++) begin
          g_fb[s][k] = g_fb[s][k+1];
          g_fs[s][k] = g_fs[s][k+1];
        end
        g_fc[s]--;
      end else begin
        g_fb[s][i] = b + r.length;
        g_fs[s][i] = g_fs[s][i] - r.length;
      end
    end else begin
      for (i = 0; i < g_uc[s]; i++) if (g_ub[s][i] == r.block_address) break;
      if (i >= g_uc[s] || g_fc[s] >= NFREE) return;
      sz = g_us[s][i];
      for (k = i; k + 1 < g_uc[s]; k++) begin
        g_ub[s][k] = g_ub[s][k+1];
        g_us[s][k] = g_us[s][k+1];
      end
      g_uc[s]--;
      for (k = g_fc[s]; k > 0; k--) begin
        g_fb[s][k] = g_fb[s][k-1];
        g_fs[s][k] = g_fs[s][k-1];
      end
      g_fb[s][0] = r.block_address;
      g_fs[s][0] = sz;
      g_fc[s]++;
    end
    for (s = 0; s < 2; s++) begin
      live_bases[s].delete();
      live_lens[s].delete();
      for (i = 0; i < g_uc[s]; i++) live_bases[s].push_back(g_ub[s][i]);
      for (i = 0; i < g_fc[s]; i++) live_lens[s].push_back(g_fs[s][i]);
    end
  endtask

  task automatic gen(req_t r);
    shadow_apply(r);
    push_req(r);
  endtask

  function automatic bit in_flight_now();
    return start;
  endfunction

  // accept tracking at rising edge, drive at falling edge
  bit accepted;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    accepted = !rst && start && !busy;
    if (accepted) begin
      expected_rsps.push_back(predict_alloc_free(request));
      n_sent <= n_sent + 1;
    end
    if (!rst && done) begin
      if (expected_rsps.size() == 0) begin
        $display("%0t: unexpected response addr=%h status=%0d", $time,
                 response.result_address, response.status);
        errors++;
      end else begin
        rsp_t e;
        e = expected_rsps.pop_front();
        if (e.result_address !== response.result_address)
          $display("%0t: result_address expected %h actual %h", $time,
                   e.result_address, response.result_address);
        if (e.status !== response.status)
          $display("%0t: status expected %0d actual %0d", $time,
                   e.status, response.status);
        if (e !== response) errors++;
        status_seen[response.status]++;
        n_checked++;
      end
    end
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("** first_fit_segment_allocator_top: FAILED **");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (accepted || !start) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        gap_left <= $urandom_range(0, 18);
        start <= 1'b0;
      end else if (drain_hold || pending_reqs.size() == 0) begin
        start <= 1'b0;
      end else begin
        request <= pending_reqs.pop_front();
        start <= 1'b1;
      end
    end
  end

  initial begin
    int i, s, sel;
    for (s = 0; s < 2; s++) begin
      g_fb[s][0] = 0;
      g_fs[s][0] = 16'hffff;
      g_fc[s] = 1;
      g_uc[s] = 0;
      fl_base[s][0] = 0;
      fl_size[s][0] = 16'hffff;
      fl_cnt[s] = 1;
      ul_cnt[s] = 0;
    end
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: zero length, miss, exact fit of whole segment, empty list
    gen(make_req(FUNC_ALLOC, 1'b0, 16'd0, 16'hffff, 8'hff));
    gen(make_req(FUNC_FREE, 1'b1, 16'hffff, 16'h0000, 8'h00));
    gen(make_req(FUNC_ALLOC, 1'b1, 16'hffff, 16'h0, 8'hff));
    gen(make_req(FUNC_ALLOC, 1'b1, 16'd1, 16'h0, 8'h00));
    gen(make_req(FUNC_FREE, 1'b1, 16'd0, 16'h0000, 8'h00));
    gen(make_req(FUNC_ALLOC, 1'b1, 16'hffff, 16'hffff, 8'ha5));
    gen(make_req(FUNC_FREE, 1'b1, 16'd0, 16'h0000, 8'h5a));
    // fill the segment 0 used table, then one more for table full
    for (i = 0; i < NUSED + 1; i++)
      gen(make_req(FUNC_ALLOC, 1'b0, 16'd16, 16'h0, 8'(i)));
    gen(make_req(FUNC_FREE, 1'b0, 16'd0, 16'h1234, 8'h00));

    // random, mostly consistent alloc/free traffic
    for (i = 0; i < 1630; i++) begin
      sel = $urandom_range(0, 9);
      gen(random_req(sel > 6 ? sel - 4 : sel % 5));
      if (i == 600) begin
        while (pending_reqs.size() != 0) @(posedge clk);
        drain_hold = 1'b1;
        while (expected_rsps.size() != 0 || in_flight_now()) @(posedge clk);
        drain_hold = 1'b0;
      end
      if (i == 1400) begin
        while (pending_reqs.size() != 0) @(posedge clk);
        quiet = 1'b1;
      end
    end

    while (pending_reqs.size() != 0 || start) @(posedge clk);
    while (expected_rsps.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
    $display("ran %0d transactions, %0d responses checked", n_sent, n_checked);
    $display("status ok/miss/zero/full: %0d/%0d/%0d/%0d", status_seen[0],
             status_seen[1], status_seen[2], status_seen[3]);
    if (errors == 0 && expected_rsps.size() == 0) begin
      $display("** first_fit_segment_allocator_top: PASSED **");
    end else begin
      $display("** first_fit_segment_allocator_top: FAILED **");
    end
    $finish;
  end

endmodule
